[rtl/core/prtbf_pkg.sv]
// Shared types, constants and helpers for the point rotate/translate/box filter.
// No dependencies.
package prtbf_pkg;

   localparam int COORD_W   = 32;
   localparam int ROT_W     = 16;
   localparam int HALF_W    = 31;
   localparam int ROT_FRAC  = 14;
   localparam int PROD_W    = COORD_W + ROT_W;            // 48
   localparam int SUM_W     = PROD_W + 1;                 // 49
   localparam int RND_W     = SUM_W - ROT_FRAC;           // 35
   localparam int NEW_W     = RND_W + 1;                  // 36
   localparam int NX_W      = COORD_W + 1;                // 33
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_COS_ROT      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_ROT      = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y     = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z     = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH_X = 8'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH_Y = 8'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_Z      = 8'd7;

   localparam logic signed [ROT_W-1:0]   COS_ROT_RST      = 16'sd16384;
   localparam logic signed [ROT_W-1:0]   SIN_ROT_RST      = 16'sd0;
   localparam logic        [HALF_W-1:0]  HALF_WIDTH_RST   = 31'd65536;
   localparam logic signed [COORD_W-1:0] COORD_ZERO       = 32'sd0;

   localparam logic signed [SUM_W-1:0]   RND_HALF = SUM_W'(1) <<< (ROT_FRAC - 1);

   typedef struct packed {
      logic signed [ROT_W-1:0]   cos_rot;
      logic signed [ROT_W-1:0]   sin_rot;
      logic signed [COORD_W-1:0] offset_x;
      logic signed [COORD_W-1:0] offset_y;
      logic signed [COORD_W-1:0] offset_z;
      logic        [HALF_W-1:0]  half_width_x;
      logic        [HALF_W-1:0]  half_width_y;
      logic signed [COORD_W-1:0] floor_z;
   } cfg_type;

   // one word from the front part to the back part
   typedef struct packed {
      logic [NX_W-1:0]   nx;
      logic [PROD_W-1:0] y_cos;
      logic [PROD_W-1:0] z_sin;
      logic [PROD_W-1:0] y_sin;
      logic [PROD_W-1:0] z_cos;
      logic              x_ok;
      logic              filter_on;
   } entry_type;

   localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   function automatic logic signed [COORD_W-1:0] sat_new(input logic signed [NEW_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > NEW_W'(SAT_MAX))
         r = SAT_MAX;
      else if (v < NEW_W'(SAT_MIN))
         r = SAT_MIN;
      else
         r = v[COORD_W-1:0];
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_nx(input logic signed [NX_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v[NX_W-1] != v[NX_W-2])
         r = v[NX_W-1] ? SAT_MIN : SAT_MAX;
      else
         r = v[COORD_W-1:0];
      return r;
   endfunction

endpackage

[rtl/core/prtbf_front.sv]
// Front part: takes a point word, forms the four rotation products, the x result
// and the x box test, and registers them. Depends on prtbf_pkg.
module prtbf_front import prtbf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic signed [COORD_W-1:0] x_in,
   input  logic signed [COORD_W-1:0] y_in,
   input  logic signed [COORD_W-1:0] z_in,
   input  logic                      filter_on,
   input  cfg_type                   cfg,
   output logic                      push,
   output entry_type                 entry
);

   logic                      valid_ff, valid_in;
   entry_type                 entry_ff, entry_in;
   logic signed [PROD_W-1:0]  y_cos, z_sin, y_sin, z_cos;
   logic signed [NX_W-1:0]    nx;
   logic        [COORD_W-1:0] ax;

   assign y_cos = PROD_W'(y_in) * PROD_W'(cfg.cos_rot);
   assign z_sin = PROD_W'(z_in) * PROD_W'(cfg.sin_rot);
   assign y_sin = PROD_W'(y_in) * PROD_W'(cfg.sin_rot);
   assign z_cos = PROD_W'(z_in) * PROD_W'(cfg.cos_rot);
   assign nx    = NX_W'(cfg.offset_x) - NX_W'(x_in);
   assign ax    = x_in[COORD_W-1] ? (~x_in + 1'b1) : x_in;

   always_comb begin
      valid_in           = accept;
      entry_in.nx        = nx;
      entry_in.y_cos     = y_cos;
      entry_in.z_sin     = z_sin;
      entry_in.y_sin     = y_sin;
      entry_in.z_cos     = z_cos;
      entry_in.x_ok      = ax < {1'b0, cfg.half_width_x};
      entry_in.filter_on = filter_on;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign push  = valid_ff;
   assign entry = entry_ff;

endmodule

[rtl/core/prtbf_queue.sv]
// Short word queue between front and back parts.
// Depends on prtbf_pkg.
module prtbf_queue import prtbf_pkg::*; #(
   parameter int ADDR_W = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      not_empty,
   output logic      near_full
);

   localparam int DEPTH = 1 << ADDR_W;

   entry_type         mem_ff [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W:0]   count_ff, count_in;
   logic              do_pop;

   assign do_pop    = pop && (count_ff != '0);
   assign wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (!push && do_pop)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   // one slot is kept for the word still in the front register
   assign near_full = count_ff >= (ADDR_W+1)'(DEPTH - 1);

endmodule

[rtl/core/prtbf_back.sv]
// Back part: rounds the rotation sums, adds offsets, runs the y/z box tests,
// saturates and drives the result word. Depends on prtbf_pkg.
module prtbf_back import prtbf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   input  entry_type                  entry,
   input  cfg_type                    cfg,
   output logic                       rsp_valid,
   output logic signed [COORD_W-1:0]  rsp_x_out,
   output logic signed [COORD_W-1:0]  rsp_y_out,
   output logic signed [COORD_W-1:0]  rsp_z_out
);

   logic                      a_valid_ff, a_valid_in;
   logic signed [RND_W-1:0]   a_y_ff, a_y_in, a_z_ff, a_z_in;
   logic signed [NX_W-1:0]    a_nx_ff;
   logic                      a_x_ok_ff, a_filt_ff;
   logic signed [SUM_W-1:0]   sum_y, sum_z;

   logic                      out_valid_ff, out_valid_in;
   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic signed [NEW_W-1:0]   ny, nz;
   logic        [NEW_W-1:0]   ay;
   logic                      keep;

   assign sum_y  = SUM_W'($signed(entry.y_cos)) + SUM_W'($signed(entry.z_sin)) + RND_HALF;
   assign sum_z  = SUM_W'($signed(entry.y_sin)) - SUM_W'($signed(entry.z_cos)) + RND_HALF;
   assign a_y_in = sum_y[SUM_W-1:ROT_FRAC];
   assign a_z_in = sum_z[SUM_W-1:ROT_FRAC];
   assign a_valid_in = take;

   assign ny = NEW_W'(a_y_ff) + NEW_W'(cfg.offset_y);
   assign nz = NEW_W'(a_z_ff) + NEW_W'(cfg.offset_z);
   assign ay = ny[NEW_W-1] ? (~ny + 1'b1) : ny;
   assign keep = !a_filt_ff || (a_x_ok_ff
                                && (ay < NEW_W'(cfg.half_width_y))
                                && (nz > NEW_W'(cfg.floor_z)));
   assign out_valid_in = a_valid_ff && keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (take) begin
         a_y_ff    <= a_y_in;
         a_z_ff    <= a_z_in;
         a_nx_ff   <= entry.nx;
         a_x_ok_ff <= entry.x_ok;
         a_filt_ff <= entry.filter_on;
      end
      if (out_valid_in) begin
         x_ff <= sat_nx(a_nx_ff);
         y_ff <= sat_new(ny);
         z_ff <= sat_new(nz);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_x_out = x_ff;
   assign rsp_y_out = y_ff;
   assign rsp_z_out = z_ff;

endmodule

[rtl/core/point_rotate_translate_box_filter_top.sv]
// Top level: register file, front part, queue and back part.
// Depends on prtbf_pkg, prtbf_front, prtbf_queue, prtbf_back.
// A point taken with start passes the front register, the queue and the back
// part's two registers before rsp_valid rises; a rejected point gives no result.
// Throughput: one point per cycle, set by the fully pipelined multiply and add
// stages; the receiver cannot stall, so busy stays low in use. Reset (synchronous,
// active high) empties the pipeline and queue and loads the register defaults.
module point_rotate_translate_box_filter_top import prtbf_pkg::*; #(
   parameter int QUEUE_ADDR_W = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [COORD_W-1:0]  req_x_in,
   input  logic signed [COORD_W-1:0]  req_y_in,
   input  logic signed [COORD_W-1:0]  req_z_in,
   input  logic                       req_filter_on,
   output logic                       rsp_valid,
   output logic signed [COORD_W-1:0]  rsp_x_out,
   output logic signed [COORD_W-1:0]  rsp_y_out,
   output logic signed [COORD_W-1:0]  rsp_z_out,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DAT_W-1:0]       csr_data
);

   cfg_type   cfg_ff, cfg_in;
   logic      accept, push, not_empty, near_full;
   entry_type front_entry, head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COS_ROT:      cfg_in.cos_rot      = csr_data[ROT_W-1:0];
            CSR_SIN_ROT:      cfg_in.sin_rot      = csr_data[ROT_W-1:0];
            CSR_OFFSET_X:     cfg_in.offset_x     = csr_data[COORD_W-1:0];
            CSR_OFFSET_Y:     cfg_in.offset_y     = csr_data[COORD_W-1:0];
            CSR_OFFSET_Z:     cfg_in.offset_z     = csr_data[COORD_W-1:0];
            CSR_HALF_WIDTH_X: cfg_in.half_width_x = csr_data[HALF_W-1:0];
            CSR_HALF_WIDTH_Y: cfg_in.half_width_y = csr_data[HALF_W-1:0];
            CSR_FLOOR_Z:      cfg_in.floor_z      = csr_data[COORD_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_rot      <= COS_ROT_RST;
         cfg_ff.sin_rot      <= SIN_ROT_RST;
         cfg_ff.offset_x     <= COORD_ZERO;
         cfg_ff.offset_y     <= COORD_ZERO;
         cfg_ff.offset_z     <= COORD_ZERO;
         cfg_ff.half_width_x <= HALF_WIDTH_RST;
         cfg_ff.half_width_y <= HALF_WIDTH_RST;
         cfg_ff.floor_z      <= COORD_ZERO;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign busy   = near_full;
   assign accept = start && !busy;

   prtbf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .x_in      (req_x_in),
      .y_in      (req_y_in),
      .z_in      (req_z_in),
      .filter_on (req_filter_on),
      .cfg       (cfg_ff),
      .push      (push),
      .entry     (front_entry)
   );

   prtbf_queue #(
      .ADDR_W (QUEUE_ADDR_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (not_empty),
      .head       (head),
      .not_empty  (not_empty),
      .near_full  (near_full)
   );

   prtbf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .take      (not_empty),
      .entry     (head),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_x_out (rsp_x_out),
      .rsp_y_out (rsp_y_out),
      .rsp_z_out (rsp_z_out)
   );

endmodule
